>>> src/fcal_pkg.sv
// Shared operation codes, status codes and field widths for the array list.
`timescale 1ns / 1ps

package fcal_pkg;

   localparam int KIND_W   = 3;
   localparam int POS_W    = 4;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int ECOUNT_W = 5;

   typedef logic [KIND_W-1:0]   kind_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam kind_type KIND_APPEND    = 3'd0;
   localparam kind_type KIND_INSERT    = 3'd1;
   localparam kind_type KIND_POP_FRONT = 3'd2;
   localparam kind_type KIND_POP_BACK  = 3'd3;
   localparam kind_type KIND_POP_AT    = 3'd4;
   localparam kind_type KIND_READ      = 3'd5;
   localparam kind_type KIND_FIND      = 3'd6;
   localparam kind_type KIND_CLEAR     = 3'd7;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD       = 2'd1;
   localparam status_type STATUS_EMPTY     = 2'd2;
   localparam status_type STATUS_NOT_FOUND = 2'd3;

endpackage

>>> src/fixed_capacity_array_list.sv
// Top level of the fixed-capacity array list: entry memory and its sequencer.
`timescale 1ns / 1ps

// Dense ordered list of up to CAPACITY signed words held in a single-port-write,
// registered-read memory. One request is worked at a time; req_stall is high from
// acceptance until the result has been loaded into the output register, which
// holds it for the consumer while the next request is taken. Append, clear and
// rejected requests need no memory walk; read and pop back read one entry; pop
// front / pop at also shift the entries behind the position down; insert shifts
// them up before writing the new word; find scans every entry. The entry memory
// is walked one entry per cycle by the shift and search loops.
module fixed_capacity_array_list
   import fcal_pkg::*;
#(
   parameter int CAPACITY   = 16,
   parameter int WORD_WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [KIND_W-1:0]          req_kind,
   input  logic [POS_W-1:0]           req_position,
   input  logic signed [DATA_W-1:0]   req_data_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [DATA_W-1:0]   rsp_out_word,
   output logic [POS_W-1:0]           rsp_out_position,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [ECOUNT_W-1:0]        rsp_entry_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam int EW = (CW > ECOUNT_W) ? CW : ECOUNT_W;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_HEAD    = 3'd1;
   localparam logic [2:0] ST_RM_WALK = 3'd2;
   localparam logic [2:0] ST_INS     = 3'd3;
   localparam logic [2:0] ST_INS_PUT = 3'd4;
   localparam logic [2:0] ST_FIND    = 3'd5;
   localparam logic [2:0] ST_FINISH  = 3'd6;

   function automatic logic [DATA_W-1:0] to_out(input logic [WORD_WIDTH-1:0] w);
      logic signed [63:0] x;
      x = 64'($signed(w));
      return x[DATA_W-1:0];
   endfunction

   // entry memory
   logic [WORD_WIDTH-1:0] entries_ff [CAPACITY];
   logic [WORD_WIDTH-1:0] rd_data_ff;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [WORD_WIDTH-1:0] wr_data;

   logic [2:0]            state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CW-1:0]         walk_ff, walk_in;
   logic [AW-1:0]         pos_ff, pos_in;
   logic [WORD_WIDTH-1:0] key_ff, key_in;
   logic                  rm_ff, rm_in;
   logic                  pend_ff, pend_in;
   logic [AW-1:0]         pend_addr_ff, pend_addr_in;
   logic                  cap_ff, cap_in;
   logic                  cmp_ff, cmp_in;
   logic [AW-1:0]         cmp_idx_ff, cmp_idx_in;
   logic                  hit_ff, hit_in;
   logic [AW-1:0]         hit_idx_ff, hit_idx_in;
   logic [DATA_W-1:0]     word_ff, word_in;
   logic [AW-1:0]         opos_ff, opos_in;
   logic [STATUS_W-1:0]   status_ff, status_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_word_ff, rsp_word_in;
   logic [POS_W-1:0]      rsp_pos_ff, rsp_pos_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ECOUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                  accept;
   logic [PW-1:0]         pos_p;
   logic [PW-1:0]         cnt_p;
   logic                  full;
   logic                  empty;
   logic [CW-1:0]         cnt_m1;
   logic [CW-1:0]         walk_p1;
   logic [CW-1:0]         walk_m1;
   logic signed [63:0]    data_ext;
   logic [WORD_WIDTH-1:0] req_key;
   logic [PW-1:0]         opos_ext;
   logic [EW-1:0]         count_ext;
   logic                  match;

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign pos_p    = PW'(req_position);
   assign cnt_p    = PW'(count_ff);
   assign full     = (count_ff == CW'(CAPACITY));
   assign empty    = (count_ff == '0);
   assign cnt_m1   = count_ff - CW'(1);
   assign walk_p1  = walk_ff + CW'(1);
   assign walk_m1  = walk_ff - CW'(1);
   assign data_ext = 64'(req_data_word);
   assign req_key  = data_ext[WORD_WIDTH-1:0];
   assign match    = cmp_ff && (rd_data_ff == key_ff);
   assign opos_ext = PW'(opos_ff);
   assign count_ext = EW'(count_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      walk_in      = walk_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      rm_in        = rm_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      cap_in       = 1'b0;
      cmp_in       = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      word_in      = word_ff;
      opos_in      = opos_ff;
      status_in    = status_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      wr_en        = 1'b0;
      wr_addr      = pend_addr_ff;
      wr_data      = rd_data_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_word_in   = rsp_word_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      // complete the shift move whose read was issued last cycle
      if (pend_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in    = req_key;
               word_in   = '0;
               opos_in   = '0;
               status_in = STATUS_OK;
               rm_in     = 1'b1;
               hit_in    = 1'b0;
               state_in  = ST_FINISH;
               case (req_kind)
                  KIND_APPEND: begin
                     if (full) begin
                        status_in = STATUS_BAD;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[AW-1:0];
                        wr_data  = req_key;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  KIND_INSERT: begin
                     if ((pos_p < cnt_p) && !full) begin
                        pos_in   = pos_p[AW-1:0];
                        walk_in  = cnt_m1;
                        state_in = ST_INS;
                     end else begin
                        status_in = STATUS_BAD;
                     end
                  end
                  KIND_POP_FRONT: begin
                     if (empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        pos_in   = '0;
                        state_in = ST_HEAD;
                     end
                  end
                  KIND_POP_BACK: begin
                     if (empty) begin
                        status_in = STATUS_EMPTY;
                     end else begin
                        pos_in   = cnt_m1[AW-1:0];
                        state_in = ST_HEAD;
                     end
                  end
                  KIND_POP_AT, KIND_READ: begin
                     if (empty) begin
                        status_in = STATUS_EMPTY;
                     end else if (pos_p >= cnt_p) begin
                        status_in = STATUS_BAD;
                     end else begin
                        pos_in   = pos_p[AW-1:0];
                        rm_in    = (req_kind == KIND_POP_AT);
                        state_in = ST_HEAD;
                     end
                  end
                  KIND_FIND: begin
                     walk_in  = '0;
                     state_in = ST_FIND;
                  end
                  KIND_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     status_in = STATUS_BAD;
                  end
               endcase
            end
         end

         ST_HEAD: begin
            rd_en    = 1'b1;
            rd_addr  = pos_ff;
            cap_in   = 1'b1;
            // a plain read skips the shift walk entirely
            walk_in  = rm_ff ? (CW'(pos_ff) + CW'(1)) : count_ff;
            state_in = ST_RM_WALK;
         end

         ST_RM_WALK: begin
            if (cap_ff) begin
               word_in = to_out(rd_data_ff);
            end
            if (walk_ff < count_ff) begin
               rd_en        = 1'b1;
               rd_addr      = walk_ff[AW-1:0];
               pend_in      = 1'b1;
               pend_addr_in = walk_m1[AW-1:0];
               walk_in      = walk_p1;
            end else begin
               if (rm_ff) begin
                  count_in = cnt_m1;
               end
               state_in = ST_FINISH;
            end
         end

         ST_INS: begin
            rd_en        = 1'b1;
            rd_addr      = walk_ff[AW-1:0];
            pend_in      = 1'b1;
            pend_addr_in = walk_p1[AW-1:0];
            if (walk_ff[AW-1:0] == pos_ff) begin
               state_in = ST_INS_PUT;
            end else begin
               walk_in = walk_m1;
            end
         end

         ST_INS_PUT: begin
            // wait for the last move to land before dropping the new word in
            if (!pend_ff) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = key_ff;
               count_in = count_ff + CW'(1);
               state_in = ST_FINISH;
            end
         end

         ST_FIND: begin
            if (match) begin
               hit_in     = 1'b1;
               hit_idx_in = cmp_idx_ff;
            end
            if (walk_ff < count_ff) begin
               rd_en      = 1'b1;
               rd_addr    = walk_ff[AW-1:0];
               cmp_in     = 1'b1;
               cmp_idx_in = walk_ff[AW-1:0];
               walk_in    = walk_p1;
            end else begin
               if (hit_ff || match) begin
                  status_in = STATUS_OK;
                  opos_in   = match ? cmp_idx_ff : hit_idx_ff;
               end else begin
                  status_in = STATUS_NOT_FOUND;
               end
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_word_in   = word_ff;
               rsp_pos_in    = opos_ext[POS_W-1:0];
               rsp_status_in = status_ff;
               rsp_count_in  = count_ext[ECOUNT_W-1:0];
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         cap_ff       <= 1'b0;
         cmp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         cap_ff       <= cap_in;
         cmp_ff       <= cmp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff       <= walk_in;
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      rm_ff         <= rm_in;
      pend_addr_ff  <= pend_addr_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      word_ff       <= word_in;
      opos_ff       <= opos_in;
      status_ff     <= status_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall        = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_word     = rsp_word_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_count  = rsp_count_ff;

endmodule

>>> verif/fcal_checker.sv
// Checker for the array list: tracks the list contents and compares every result transaction.
`timescale 1ns / 1ps

module fcal_checker
   import fcal_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  logic [KIND_W-1:0]        req_kind,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_data_word,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  logic signed [DATA_W-1:0] rsp_out_word,
   input  logic [POS_W-1:0]         rsp_out_position,
   input  logic [STATUS_W-1:0]      rsp_status,
   input  logic [ECOUNT_W-1:0]      rsp_entry_count,
   output int                       mismatch_count,
   output int                       waiting_count,
   output int                       results_seen,
   output int                       full_rejects
);

   localparam int LIST_DEPTH = 16;

   typedef struct {
      logic signed [DATA_W-1:0] word;
      logic [POS_W-1:0]         position;
      status_type               status;
      logic [ECOUNT_W-1:0]      entry_count;
   } list_result_type;

   logic signed [DATA_W-1:0] shadow_words [LIST_DEPTH];
   int                       shadow_len;
   list_result_type          pending_list_results [$];
   list_result_type          oldest;

   // Remove one entry and close the gap behind it.
   function automatic logic signed [DATA_W-1:0] take_entry(int slot);
      logic signed [DATA_W-1:0] taken;
      taken = shadow_words[slot];
      for (int i = slot; i + 1 < shadow_len; i++)
         shadow_words[i] = shadow_words[i + 1];
      shadow_len--;
      return taken;
   endfunction

   function automatic list_result_type apply_list_op(kind_type kind, logic [POS_W-1:0] pos,
                                                     logic signed [DATA_W-1:0] data);
      list_result_type res;
      bit              hit;
      res.word     = '0;
      res.position = '0;
      res.status   = STATUS_OK;
      hit          = 1'b0;
      case (kind)
         KIND_APPEND: begin
            if (shadow_len < LIST_DEPTH) begin
               shadow_words[shadow_len] = data;
               shadow_len++;
            end else begin
               res.status = STATUS_BAD;
               full_rejects++;
            end
         end
         KIND_INSERT: begin
            if (pos < shadow_len && shadow_len < LIST_DEPTH) begin
               for (int i = shadow_len; i > pos; i--)
                  shadow_words[i] = shadow_words[i - 1];
               shadow_words[pos] = data;
               shadow_len++;
            end else begin
               res.status = STATUS_BAD;
               if (shadow_len == LIST_DEPTH)
                  full_rejects++;
            end
         end
         KIND_POP_FRONT: begin
            if (shadow_len == 0)
               res.status = STATUS_EMPTY;
            else
               res.word = take_entry(0);
         end
         KIND_POP_BACK: begin
            if (shadow_len == 0) begin
               res.status = STATUS_EMPTY;
            end else begin
               shadow_len--;
               res.word = shadow_words[shadow_len];
            end
         end
         KIND_POP_AT: begin
            if (shadow_len == 0)
               res.status = STATUS_EMPTY;
            else if (pos >= shadow_len)
               res.status = STATUS_BAD;
            else
               res.word = take_entry(pos);
         end
         KIND_READ: begin
            if (shadow_len == 0)
               res.status = STATUS_EMPTY;
            else if (pos >= shadow_len)
               res.status = STATUS_BAD;
            else
               res.word = shadow_words[pos];
         end
         KIND_FIND: begin
            // keep the last match
            for (int i = 0; i < shadow_len; i++) begin
               if (shadow_words[i] == data) begin
                  hit          = 1'b1;
                  res.position = i[POS_W-1:0];
               end
            end
            if (!hit)
               res.status = STATUS_NOT_FOUND;
         end
         default: shadow_len = 0;
      endcase
      res.entry_count = shadow_len[ECOUNT_W-1:0];
      return res;
   endfunction

   task automatic check_field(input string field_name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field_name, want, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         shadow_len = 0;
         pending_list_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_list_results.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: unexpected result, expected none, got word %0d status %0d",
                        $time, rsp_out_word, rsp_status);
            end else begin
               oldest = pending_list_results.pop_front();
               check_field("out_word", oldest.word, rsp_out_word);
               check_field("out_position", oldest.position, rsp_out_position);
               check_field("status", oldest.status, rsp_status);
               check_field("entry_count", oldest.entry_count, rsp_entry_count);
               results_seen++;
            end
         end
         if (req_valid && !req_stall)
            pending_list_results.push_back(apply_list_op(req_kind, req_position,
                                                         req_data_word));
      end
      waiting_count = pending_list_results.size();
   end

endmodule

>>> verif/tb.sv
// Testbench top for the array list: clock, reset, stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb;
   import fcal_pkg::*;

   localparam int RANDOM_OPS  = 1200;
   localparam int PHASE_LEN   = 60;
   localparam int QUIET_LIMIT = 2000;

   logic                     clock;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [KIND_W-1:0]        req_kind       = KIND_APPEND;
   logic [POS_W-1:0]         req_position   = '0;
   logic signed [DATA_W-1:0] req_data_word  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b0;
   logic signed [DATA_W-1:0] rsp_out_word;
   logic [POS_W-1:0]         rsp_out_position;
   logic [STATUS_W-1:0]      rsp_status;
   logic [ECOUNT_W-1:0]      rsp_entry_count;

   int mismatch_count;
   int waiting_count;
   int results_seen;
   int full_rejects;
   int ops_sent;
   bit steady_send;

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   fixed_capacity_array_list DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_out_position (rsp_out_position),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count)
   );

   fcal_checker list_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_position     (req_position),
      .req_data_word    (req_data_word),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_word     (rsp_out_word),
      .rsp_out_position (rsp_out_position),
      .rsp_status       (rsp_status),
      .rsp_entry_count  (rsp_entry_count),
      .mismatch_count   (mismatch_count),
      .waiting_count    (waiting_count),
      .results_seen     (results_seen),
      .full_rejects     (full_rejects)
   );

   // Called at a falling edge; returns at the falling edge after acceptance.
   task automatic send_op(input kind_type kind, input logic [POS_W-1:0] pos,
                          input logic signed [DATA_W-1:0] data);
      while (!steady_send && $urandom_range(0, 99) < 22) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_position  <= pos;
      req_data_word <= data;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      ops_sent++;
      @(negedge clock);
   endtask

   // Small values make finds hit; the rest toggles every bit and hits the extremes.
   function automatic logic signed [DATA_W-1:0] pick_word();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5)
         return $urandom_range(0, 7) - 4;
      if (r < 8)
         return $urandom();
      case ($urandom_range(0, 3))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'sd0;
         default: return -32'sd1;
      endcase
   endfunction

   function automatic kind_type pick_kind(bit growing);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 10)
         return kind_type'($urandom_range(0, 7));
      if (growing) begin
         if (r < 50) return KIND_APPEND;
         if (r < 72) return KIND_INSERT;
         if (r < 82) return KIND_READ;
         if (r < 92) return KIND_FIND;
         if (r < 94) return KIND_POP_FRONT;
         if (r < 96) return KIND_POP_BACK;
         if (r < 99) return KIND_POP_AT;
         return KIND_CLEAR;
      end
      if (r < 28) return KIND_POP_FRONT;
      if (r < 46) return KIND_POP_BACK;
      if (r < 64) return KIND_POP_AT;
      if (r < 74) return KIND_READ;
      if (r < 84) return KIND_FIND;
      if (r < 90) return KIND_APPEND;
      if (r < 99) return KIND_INSERT;
      return KIND_CLEAR;
   endfunction

   initial begin : stimulus
      logic [POS_W-1:0] pos;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty list
      send_op(KIND_POP_FRONT, 4'd0, 32'sd0);
      send_op(KIND_POP_BACK, 4'd15, 32'sd0);
      send_op(KIND_POP_AT, 4'd0, 32'sd0);
      send_op(KIND_READ, 4'd0, 32'sd0);
      send_op(KIND_FIND, 4'd0, 32'sd0);
      send_op(KIND_INSERT, 4'd0, 32'sd9);
      // extremes, then shifting inserts and a duplicate for find
      send_op(KIND_APPEND, 4'd15, 32'h7FFF_FFFF);
      send_op(KIND_APPEND, 4'd0, 32'h8000_0000);
      send_op(KIND_APPEND, 4'd0, 32'sd0);
      send_op(KIND_APPEND, 4'd0, -32'sd1);
      send_op(KIND_INSERT, 4'd0, 32'sd7);
      send_op(KIND_INSERT, 4'd2, 32'h7FFF_FFFF);
      send_op(KIND_FIND, 4'd0, 32'h7FFF_FFFF);
      send_op(KIND_FIND, 4'd0, 32'sd12345);
      send_op(KIND_READ, 4'd15, 32'sd0);
      send_op(KIND_POP_AT, 4'd15, 32'sd0);
      send_op(KIND_POP_AT, 4'd1, 32'sd0);
      send_op(KIND_POP_FRONT, 4'd0, 32'sd0);
      send_op(KIND_POP_BACK, 4'd0, 32'sd0);
      send_op(KIND_READ, 4'd0, 32'sd0);
      // fill to capacity, then append and insert on a full list
      repeat (14)
         send_op(KIND_APPEND, 4'd0, pick_word());
      send_op(KIND_INSERT, 4'd0, 32'sd1);
      send_op(KIND_READ, 4'd15, 32'sd0);
      send_op(KIND_CLEAR, 4'd0, 32'sd0);

      for (int n = 0; n < RANDOM_OPS; n++) begin
         steady_send = (n >= 400 && n < 600);
         if ($urandom_range(0, 1) == 0)
            pos = POS_W'($urandom_range(0, 3));
         else
            pos = POS_W'($urandom_range(0, 15));
         send_op(pick_kind((n / PHASE_LEN) % 2 == 0), pos, pick_word());
      end
      req_valid <= 1'b0;

      while (waiting_count != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Sent %0d list operations over grow and drain phases; %0d results compared,",
               ops_sent, results_seen);
      $display("%0d appends or inserts turned away by a full list.", full_rejects);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: random stalls, a stretch with none, and two long hold-offs.
   initial begin : receiver
      int cyc;
      int hold_left;
      cyc       = 0;
      hold_left = 0;
      wait (!reset);
      forever begin
         @(negedge clock);
         cyc++;
         if (cyc == 1000 || cyc == 9000)
            hold_left = 120;
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (cyc >= 4000 && cyc < 6000) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < 22);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet = 0;
         else
            quiet++;
      end
      $display("Timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
